// ===== rtl/ursq_pkg.sv =====
// ----------------------------------------------------------------------------
// ursq_pkg
// Shared types and constants for the ultrasonic range sequencer.
// ----------------------------------------------------------------------------
package ursq_pkg;

  localparam int unsigned DwellW   = 24;
  localparam int unsigned TrigW    = 8;
  localparam int unsigned TimeoutW = 16;
  localparam int unsigned ScaleW   = 16;
  localparam int unsigned ElapsedW = 24;
  localparam int unsigned DistW    = 16;
  localparam int unsigned ProdW    = ElapsedW + ScaleW;
  localparam int unsigned FracW    = 16;
  localparam int unsigned AddrW    = 4;
  localparam int unsigned DataW    = 32;

  localparam logic [DwellW-1:0]   DwellReset   = 24'd60000;
  localparam logic [TrigW-1:0]    TrigReset    = 8'd10;
  localparam logic [TimeoutW-1:0] TimeoutReset = 16'd30000;
  localparam logic [ScaleW-1:0]   ScaleReset   = 16'd11141;

  localparam logic [ElapsedW-1:0] ElapsedMax = {ElapsedW{1'b1}};
  localparam logic [DistW-1:0]    DistMax    = {DistW{1'b1}};

  typedef enum logic [1:0] {
    REG_DWELL   = 2'd0,
    REG_TRIGGER = 2'd1,
    REG_TIMEOUT = 2'd2,
    REG_SCALE   = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_TRIG = 2'd1,
    PH_WAIT = 2'd2,
    PH_TIME = 2'd3
  } phase_t;

  typedef struct packed {
    logic [DwellW-1:0]   dwell_us;
    logic [TrigW-1:0]    trigger_us;
    logic [TimeoutW-1:0] echo_timeout_us;
    logic [ScaleW-1:0]   mm_per_us_q16;
  } cfg_t;

  typedef struct packed {
    logic echo_level;
    logic read_ack;
  } in_item_t;

  typedef struct packed {
    logic             trigger_out;
    logic             reading_fresh;
    logic [DistW-1:0] distance_mm;
    logic [1:0]       phase;
  } out_item_t;

endpackage

// ===== rtl/ursq_regs.sv =====
// ----------------------------------------------------------------------------
// ursq_regs
// APB configuration registers.
// ----------------------------------------------------------------------------
module ursq_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ursq_pkg::AddrW-1:0] paddr,
  input  logic [ursq_pkg::DataW-1:0] pwdata,
  output logic [ursq_pkg::DataW-1:0] prdata,
  output ursq_pkg::cfg_t             cfg
);

  ursq_pkg::reg_idx_t idx;
  logic               wr_en;

  assign idx   = ursq_pkg::reg_idx_t'(paddr[3:2]);
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dwell_us        <= ursq_pkg::DwellReset;
      cfg.trigger_us      <= ursq_pkg::TrigReset;
      cfg.echo_timeout_us <= ursq_pkg::TimeoutReset;
      cfg.mm_per_us_q16   <= ursq_pkg::ScaleReset;
    end else if (wr_en) begin
      unique case (idx)
        ursq_pkg::REG_DWELL:   cfg.dwell_us        <= pwdata[ursq_pkg::DwellW-1:0];
        ursq_pkg::REG_TRIGGER: cfg.trigger_us      <= pwdata[ursq_pkg::TrigW-1:0];
        ursq_pkg::REG_TIMEOUT: cfg.echo_timeout_us <= pwdata[ursq_pkg::TimeoutW-1:0];
        ursq_pkg::REG_SCALE:   cfg.mm_per_us_q16   <= pwdata[ursq_pkg::ScaleW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      ursq_pkg::REG_DWELL:
        prdata = {{(ursq_pkg::DataW-ursq_pkg::DwellW){1'b0}}, cfg.dwell_us};
      ursq_pkg::REG_TRIGGER:
        prdata = {{(ursq_pkg::DataW-ursq_pkg::TrigW){1'b0}}, cfg.trigger_us};
      ursq_pkg::REG_TIMEOUT:
        prdata = {{(ursq_pkg::DataW-ursq_pkg::TimeoutW){1'b0}}, cfg.echo_timeout_us};
      ursq_pkg::REG_SCALE:
        prdata = {{(ursq_pkg::DataW-ursq_pkg::ScaleW){1'b0}}, cfg.mm_per_us_q16};
      default:
        prdata = '0;
    endcase
  end

endmodule

// ===== rtl/ursq_scale.sv =====
// ----------------------------------------------------------------------------
// ursq_scale
// Echo width times Q0.16 scale, truncated to whole mm, saturating.
// ----------------------------------------------------------------------------
module ursq_scale (
  input  logic [ursq_pkg::ElapsedW-1:0] width,
  input  logic [ursq_pkg::ScaleW-1:0]   scale,
  output logic [ursq_pkg::DistW-1:0]    mm
);

  logic [ursq_pkg::ProdW-1:0] prod;
  logic                       over;

  assign prod = {{ursq_pkg::ScaleW{1'b0}}, width} * {{ursq_pkg::ElapsedW{1'b0}}, scale};
  assign over = |prod[ursq_pkg::ProdW-1:ursq_pkg::FracW+ursq_pkg::DistW];
  assign mm   = over ? ursq_pkg::DistMax
                     : prod[ursq_pkg::FracW+ursq_pkg::DistW-1:ursq_pkg::FracW];

endmodule

// ===== rtl/ursq_core.sv =====
// ----------------------------------------------------------------------------
// ursq_core
// Ping sequencer: phase, elapsed tick counter, distance and fresh flag.
// ----------------------------------------------------------------------------
module ursq_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  ursq_pkg::in_item_t item,
  input  ursq_pkg::cfg_t     cfg,
  output ursq_pkg::out_item_t res
);

  ursq_pkg::phase_t              phase, phase_next;
  logic [ursq_pkg::ElapsedW-1:0] elapsed, elapsed_next;
  logic [ursq_pkg::DistW-1:0]    distance, distance_next;
  logic                          fresh, fresh_next;
  logic [ursq_pkg::DistW-1:0]    scaled;
  logic [ursq_pkg::ElapsedW-1:0] trig_ext, tmo_ext;
  logic                          anchor, reading;

  assign trig_ext = {{(ursq_pkg::ElapsedW-ursq_pkg::TrigW){1'b0}}, cfg.trigger_us};
  assign tmo_ext  = {{(ursq_pkg::ElapsedW-ursq_pkg::TimeoutW){1'b0}}, cfg.echo_timeout_us};

  ursq_scale u_scale (
    .width (elapsed),
    .scale (cfg.mm_per_us_q16),
    .mm    (scaled)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= ursq_pkg::PH_IDLE;
      elapsed  <= '0;
      distance <= '0;
      fresh    <= 1'b0;
    end else if (step) begin
      phase    <= phase_next;
      elapsed  <= elapsed_next;
      distance <= distance_next;
      fresh    <= fresh_next;
    end
  end

  always_comb begin
    phase_next = phase;
    anchor     = 1'b0;
    reading    = 1'b0;
    unique case (phase)
      ursq_pkg::PH_IDLE: begin
        if (elapsed >= cfg.dwell_us) begin
          phase_next = ursq_pkg::PH_TRIG;
          anchor     = 1'b1;
        end
      end
      ursq_pkg::PH_TRIG: begin
        if (elapsed >= trig_ext) begin
          phase_next = ursq_pkg::PH_WAIT;
        end
      end
      ursq_pkg::PH_WAIT: begin
        if (item.echo_level) begin
          phase_next = ursq_pkg::PH_TIME;
          anchor     = 1'b1;
        end else if (elapsed >= tmo_ext) begin
          phase_next = ursq_pkg::PH_IDLE;
          anchor     = 1'b1;
        end
      end
      ursq_pkg::PH_TIME: begin
        if (!item.echo_level) begin
          phase_next = ursq_pkg::PH_IDLE;
          anchor     = 1'b1;
          reading    = 1'b1;
        end else if (elapsed >= tmo_ext) begin
          phase_next = ursq_pkg::PH_IDLE;
          anchor     = 1'b1;
        end
      end
      default: ;
    endcase

    if (anchor) begin
      elapsed_next = {{(ursq_pkg::ElapsedW-1){1'b0}}, 1'b1};
    end else if (elapsed != ursq_pkg::ElapsedMax) begin
      elapsed_next = elapsed + 1'b1;
    end else begin
      elapsed_next = elapsed;
    end

    distance_next = reading ? scaled : distance;

    if (reading) begin
      fresh_next = 1'b1;
    end else if (item.read_ack) begin
      fresh_next = 1'b0;
    end else begin
      fresh_next = fresh;
    end

    res.trigger_out   = (phase_next == ursq_pkg::PH_TRIG);
    res.reading_fresh = fresh_next;
    res.distance_mm   = distance_next;
    res.phase         = phase_next;
  end

endmodule

// ===== rtl/ultrasonic_range_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// ultrasonic_range_sequencer_top
// Ultrasonic ranging sequencer driven by one microsecond tick per transaction.
// ----------------------------------------------------------------------------
// Each accepted item is one microsecond tick and yields exactly one result
// carrying the trigger drive, fresh flag, last distance and phase after that
// tick. One item is taken per clock unless result_ready stalls the output;
// a result passes through an input register and a result register, and the
// phase, counter and width-to-millimetre multiply for a tick all complete
// combinationally in between. Configuration takes effect on the next tick.
// ----------------------------------------------------------------------------
module ultrasonic_range_sequencer_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_ready,
  input  ursq_pkg::in_item_t         item,
  output logic                       result_valid,
  input  logic                       result_ready,
  output ursq_pkg::out_item_t        result,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ursq_pkg::AddrW-1:0] paddr,
  input  logic [ursq_pkg::DataW-1:0] pwdata,
  output logic [ursq_pkg::DataW-1:0] prdata,
  output logic                       pready
);

  ursq_pkg::cfg_t      cfg;
  ursq_pkg::in_item_t  in_q;
  logic                in_q_valid;
  logic                advance;
  ursq_pkg::out_item_t res_next;

  assign pready     = 1'b1;
  assign advance    = in_q_valid && (!result_valid || result_ready);
  assign item_ready = !in_q_valid || advance;

  ursq_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  ursq_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .item (in_q),
    .cfg  (cfg),
    .res  (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (item_ready) begin
      in_q_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      in_q <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= res_next;
    end
  end

`ifndef SYNTH
  a_trig_phase: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.trigger_out == (result.phase == ursq_pkg::PH_TRIG)))
    else $error("trigger_out disagrees with phase");

  a_fresh_idle: assert property (@(posedge clk) disable iff (rst)
    (result_valid && $rose(result.reading_fresh)) |-> (result.phase == ursq_pkg::PH_IDLE))
    else $error("new reading without return to idle");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!result_valid && !in_q_valid))
    else $error("pipeline not empty after reset");
`endif

endmodule
